// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and codes for the JSON string unescaper.
// Used by the front parser, the command queue, the result sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Kind of one result word.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // What follows the content bytes of one command.
  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_DONE = 2'd1;
  localparam logic [1:0] TAIL_ERR  = 2'd2;

  // One command: up to four content bytes, sent first to last, then an optional status.
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic [1:0]      tail;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/json_string_unescape_utf8_core.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  in_byte, end_of_buffer
// output    out        out_valid / out_stall out_kind, out_byte, last_of_run
//
// The front parser takes one input word per cycle while the command queue has room.
// Each input word becomes at most one command; the back side emits one result word
// per cycle while out_stall is low, so a word that expands to n results (up to five) holds
// the back until all n of them have been emitted.
// Reset is synchronous and active high; it returns the parser to waiting for an
// opening quote and empties the queue and the output stage.
// in_stall rises only when the four-entry queue is full; out_stall freezes the output register.

module json_string_unescape_utf8_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_buffer,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);
  import jsu_pkg::*;

  logic accept;
  cmd_t front_cmd;
  logic front_cmd_valid;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;
  cmd_t head_cmd;

  // The front stalls only on a full queue, whatever the output side is doing.
  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  // Parser state machine: classifies each byte and builds the command for it.
  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_buffer (end_of_buffer),
    .cmd           (front_cmd),
    .cmd_valid     (front_cmd_valid)
  );

  // Short queue that decouples parsing from multi-byte result expansion.
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_cmd_valid),
    .push_cmd (front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .head_cmd (head_cmd),
    .empty    (queue_empty)
  );

  // Sequencer that emits the content bytes and the closing status of each command.
  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_cmd    (head_cmd),
    .empty       (queue_empty),
    .pop         (queue_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
// Front parser: accepts input words, runs the string state machine and turns each
// word into at most one command for the queue. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          end_of_buffer,
  output jsu_pkg::cmd_t      cmd,
  output logic               cmd_valid
);
  import jsu_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX1 = 3'd3;
  localparam logic [2:0] PH_BS2  = 3'd4;
  localparam logic [2:0] PH_U2   = 3'd5;
  localparam logic [2:0] PH_HEX2 = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] ONE_BYTE_MAX = 21'h7F;
  localparam logic [20:0] TWO_BYTE_MAX = 21'h7FF;

  logic [2:0]  phase, phase_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [15:0] first_unit, first_unit_next;
  logic [15:0] second_unit, second_unit_next;

  logic        is_hex;
  logic [3:0]  hex_val;
  logic [15:0] unit;
  logic [20:0] pair_cp;
  logic        closed;

  // UTF-8 encoding of a code point of up to 21 bits, at most four bytes.
  function automatic cmd_t utf8_cmd(input logic [20:0] cp);
    cmd_t r;
    r = '0;
    r.tail = TAIL_NONE;
    if (cp <= ONE_BYTE_MAX) begin
      r.nbytes   = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= TWO_BYTE_MAX) begin
      r.nbytes   = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      r.nbytes   = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.nbytes   = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    phase_next       = phase;
    digit_count_next = digit_count;
    first_unit_next  = first_unit;
    second_unit_next = second_unit;
    cmd              = '0;
    cmd.tail         = TAIL_NONE;
    closed           = 1'b0;
    unit             = {((phase == PH_HEX1) ? first_unit[11:0] : second_unit[11:0]), hex_val};
    pair_cp          = SUPP_BASE + {1'b0, first_unit[9:0], unit[9:0]};

    case (phase)
      PH_BODY: begin
        if (in_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (in_byte == CH_QUOTE) begin
          cmd.tail   = TAIL_DONE;
          phase_next = PH_IDLE;
          closed     = 1'b1;
        end else begin
          cmd.nbytes   = 3'd1;
          cmd.bytes[0] = in_byte;
        end
      end
      PH_ESC: begin
        phase_next = PH_BODY;
        cmd.nbytes = 3'd1;
        case (in_byte)
          CH_QUOTE, CH_SLASH, CH_BSLASH: cmd.bytes[0] = in_byte;
          CH_B: cmd.bytes[0] = 8'h08;
          CH_F: cmd.bytes[0] = 8'h0C;
          CH_N: cmd.bytes[0] = 8'h0A;
          CH_R: cmd.bytes[0] = 8'h0D;
          CH_T: cmd.bytes[0] = 8'h09;
          CH_U: begin
            cmd.nbytes       = 3'd0;
            phase_next       = PH_HEX1;
            digit_count_next = 2'd0;
            first_unit_next  = '0;
          end
          default: begin
            cmd.nbytes = 3'd0;
            cmd.tail   = TAIL_ERR;
            phase_next = PH_IDLE;
            closed     = 1'b1;
          end
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        if (!is_hex) begin
          cmd.tail   = TAIL_ERR;
          phase_next = PH_IDLE;
          closed     = 1'b1;
        end else begin
          if (phase == PH_HEX1) begin
            first_unit_next = unit;
          end else begin
            second_unit_next = unit;
          end
          if (digit_count != 2'd3) begin
            digit_count_next = digit_count + 2'd1;
          end else begin
            digit_count_next = 2'd0;
            if (phase == PH_HEX1) begin
              if (unit >= HIGH_SURR_LO && unit <= HIGH_SURR_HI) begin
                phase_next = PH_BS2;
              end else begin
                cmd        = utf8_cmd({5'd0, unit});
                phase_next = PH_BODY;
              end
            end else begin
              cmd        = utf8_cmd(pair_cp);
              phase_next = PH_BODY;
            end
          end
        end
      end
      PH_BS2: begin
        if (in_byte == CH_BSLASH) begin
          phase_next = PH_U2;
        end else begin
          cmd.tail   = TAIL_ERR;
          phase_next = PH_IDLE;
          closed     = 1'b1;
        end
      end
      PH_U2: begin
        if (in_byte == CH_U) begin
          phase_next       = PH_HEX2;
          digit_count_next = 2'd0;
          second_unit_next = '0;
        end else begin
          cmd.tail   = TAIL_ERR;
          phase_next = PH_IDLE;
          closed     = 1'b1;
        end
      end
      default: begin
        if (in_byte == CH_QUOTE) begin
          phase_next = PH_BODY;
        end else begin
          cmd.tail   = TAIL_ERR;
          phase_next = PH_IDLE;
          closed     = 1'b1;
        end
      end
    endcase

    // The buffer ran out while the string is still open.
    if (end_of_buffer && !closed && phase_next != PH_IDLE) begin
      cmd.tail   = TAIL_ERR;
      phase_next = PH_IDLE;
    end

    cmd_valid = accept && (cmd.nbytes != 3'd0 || cmd.tail != TAIL_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      digit_count <= 2'd0;
      first_unit  <= '0;
      second_unit <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      first_unit  <= first_unit_next;
      second_unit <= second_unit_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_queue.sv =====
// Four-entry command queue between the front parser and the result sequencer.
// Depends on jsu_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output jsu_pkg::cmd_t      head_cmd,
  output logic               empty
);
  import jsu_pkg::*;

  cmd_t       entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full     = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 3'd1;
      end else if (pop && !push) begin
        count <= count - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
// Result sequencer: walks the command at the head of the queue one result word
// per cycle, unless the output stalls, into a registered output stage. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsu_pkg::cmd_t head_cmd,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic               last_of_run
);
  import jsu_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic [1:0] kind_next;
  logic [7:0] byte_next;
  logic       final_next;

  always_comb begin
    if (idx < head_cmd.nbytes) begin
      kind_next  = KIND_BYTE;
      byte_next  = head_cmd.bytes[idx[1:0]];
      final_next = (idx + 3'd1 == head_cmd.nbytes) && (head_cmd.tail == TAIL_NONE);
    end else begin
      kind_next  = (head_cmd.tail == TAIL_DONE) ? KIND_DONE : KIND_ERR;
      byte_next  = 8'd0;
      final_next = 1'b1;
    end
  end

  assign load = !empty && (!out_valid || !out_stall);
  assign pop  = load && final_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= final_next ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind    <= kind_next;
      out_byte    <= byte_next;
      last_of_run <= final_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
// Needs jsu_pkg and json_string_unescape_utf8_core; the expected words come from
// a behavioral decoder kept inside this file.
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  // Byte codes that steer the decoder.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // Escape letters that stand for one byte: quote, slash, backslash, b, f, n, r, t.
  localparam logic [7:0] SIMPLE_ESC [8] = '{8'h22, 8'h2F, 8'h5C, 8'h62,
                                            8'h66, 8'h6E, 8'h72, 8'h74};

  // Code units at the borders of the UTF-8 length classes and surrogate ranges.
  localparam logic [15:0] BOUNDARY_UNITS [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                                 16'h0800, 16'hFFFF, 16'hDC00, 16'hDFFF};

  // Decoder phases; the numbering follows the block's own state encoding.
  typedef enum logic [2:0] {
    P_AWAIT = 3'd0,
    P_BODY  = 3'd1,
    P_ESC   = 3'd2,
    P_HEX1  = 3'd3,
    P_BS2   = 3'd4,
    P_U2    = 3'd5,
    P_HEX2  = 3'd6
  } scan_phase_e;

  // One output word as the checker sees it.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_buffer = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  json_string_unescape_utf8_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run)
  );

  // Decoder state mirrored from the block.
  scan_phase_e ph = P_AWAIT;
  logic [1:0]  ndig = 2'd0;
  logic [15:0] unit_hi = 16'h0000;
  logic [15:0] unit_lo = 16'h0000;

  out_word_t   pending_q[$];    // decoded words not yet seen on the output
  int          run_len;         // words produced by the input word being decoded
  int          sent_words = 0;
  int          mismatches = 0;
  bit          no_gaps = 1'b0;  // set for a whole string to run the sender flat out
  bit          aborted = 1'b0;  // the current string has already been closed by an error

  initial begin
    forever #6 clk = ~clk;
  end

  // Most gaps come from the small range below; now and then one comes from the large range.
  function automatic int pick_gap();
    return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(10, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Behavioral decoder
  // ---------------------------------------------------------------------------

  function automatic void add_result(logic [1:0] kind, logic [7:0] data);
    out_word_t w;
    w.kind = kind;
    w.data = data;
    w.last = 1'b0;
    pending_q.insert(pending_q.size(), w);
    run_len++;
  endfunction

  // Returns the digit value, or 16 when the byte is not a hex digit.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  function automatic void emit_utf8(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(KIND_BYTE, cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      add_result(KIND_BYTE, 8'hC0 | {3'b000, cp[10:6]});
      add_result(KIND_BYTE, 8'h80 | {2'b00, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      add_result(KIND_BYTE, 8'hE0 | {4'b0000, cp[15:12]});
      add_result(KIND_BYTE, 8'h80 | {2'b00, cp[11:6]});
      add_result(KIND_BYTE, 8'h80 | {2'b00, cp[5:0]});
    end else if (cp <= 21'h10FFFF) begin
      add_result(KIND_BYTE, 8'hF0 | {5'b00000, cp[20:18]});
      add_result(KIND_BYTE, 8'h80 | {2'b00, cp[17:12]});
      add_result(KIND_BYTE, 8'h80 | {2'b00, cp[11:6]});
      add_result(KIND_BYTE, 8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  // Advances the decoder by one accepted input word and queues the words it yields.
  function automatic void decode_word(logic [7:0] c, logic eob);
    logic       closed;
    logic [4:0] h;
    closed  = 1'b0;
    run_len = 0;
    case (ph)
      P_BODY: begin
        if (c == CH_BSLASH) begin
          ph = P_ESC;
        end else if (c == CH_QUOTE) begin
          add_result(KIND_DONE, 8'h00);
          ph = P_AWAIT;
          closed = 1'b1;
        end else begin
          add_result(KIND_BYTE, c);
        end
      end
      P_ESC: begin
        ph = P_BODY;
        case (c)
          CH_QUOTE, CH_SLASH, CH_BSLASH: add_result(KIND_BYTE, c);
          8'h62: add_result(KIND_BYTE, 8'h08);
          8'h66: add_result(KIND_BYTE, 8'h0C);
          8'h6E: add_result(KIND_BYTE, 8'h0A);
          8'h72: add_result(KIND_BYTE, 8'h0D);
          8'h74: add_result(KIND_BYTE, 8'h09);
          CH_U: begin
            ph = P_HEX1;
            ndig = 2'd0;
            unit_hi = 16'h0000;
          end
          default: begin
            add_result(KIND_ERR, 8'h00);
            ph = P_AWAIT;
            closed = 1'b1;
          end
        endcase
      end
      P_HEX1, P_HEX2: begin
        h = hex_val(c);
        if (h[4]) begin
          add_result(KIND_ERR, 8'h00);
          ph = P_AWAIT;
          closed = 1'b1;
        end else begin
          if (ph == P_HEX1) unit_hi = {unit_hi[11:0], h[3:0]};
          else unit_lo = {unit_lo[11:0], h[3:0]};
          if (ndig != 2'd3) begin
            ndig = ndig + 2'd1;
          end else begin
            ndig = 2'd0;
            if (ph == P_HEX1) begin
              // A high surrogate waits for its partner unit.
              if (unit_hi >= 16'hD800 && unit_hi <= 16'hDBFF) begin
                ph = P_BS2;
              end else begin
                emit_utf8({5'b00000, unit_hi});
                ph = P_BODY;
              end
            end else begin
              // The partner is not checked to be a low surrogate.
              emit_utf8(21'h10000 + {1'b0, unit_hi[9:0], 10'b0} + {11'b0, unit_lo[9:0]});
              ph = P_BODY;
            end
          end
        end
      end
      P_BS2: begin
        if (c == CH_BSLASH) begin
          ph = P_U2;
        end else begin
          add_result(KIND_ERR, 8'h00);
          ph = P_AWAIT;
          closed = 1'b1;
        end
      end
      P_U2: begin
        if (c == CH_U) begin
          ph = P_HEX2;
          ndig = 2'd0;
          unit_lo = 16'h0000;
        end else begin
          add_result(KIND_ERR, 8'h00);
          ph = P_AWAIT;
          closed = 1'b1;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          ph = P_BODY;
        end else begin
          add_result(KIND_ERR, 8'h00);
          ph = P_AWAIT;
          closed = 1'b1;
        end
      end
    endcase
    // The buffer ran out with the string still open.
    if (eob && !closed && ph != P_AWAIT) begin
      add_result(KIND_ERR, 8'h00);
      ph = P_AWAIT;
    end
    if (run_len > 0) begin
      pending_q[pending_q.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall and the checker
  // ---------------------------------------------------------------------------

  // The receiver alternates between free-running stretches and stall bursts.
  initial begin : out_stall_gen
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
               what, want.kind, want.data, want.last, got.kind, got.data, got.last);
  endtask

  // Every accepted output word is matched against the oldest decoded word.
  always @(posedge clk) begin : check_out
    out_word_t got;
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {out_kind, out_byte, last_of_run};
      if (pending_q.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = pending_q.pop_front();
        if (got != want) note_mismatch("wrong word", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one word, holding it steady until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic eob);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(b, eob);
    sent_words++;
  endtask

  task automatic send_text(input string s, input bit eob_last);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], eob_last && (i == s.len() - 1));
  endtask

  // Body byte of a random string; now and then it is marked as the end of the buffer.
  task automatic send_body(input logic [7:0] b);
    logic eob;
    eob = ($urandom_range(0, 39) == 0);
    send_word(b, eob);
    if (eob) aborted = 1'b1;
  endtask

  // Lowers valid and holds off until every decoded word has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] rand_not_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_val(b) != 5'd16);
    return b;
  endfunction

  function automatic logic [7:0] rand_bad_escape();
    logic [7:0] b;
    bit         known;
    do begin
      b = 8'($urandom_range(0, 255));
      known = (b == CH_U);
      foreach (SIMPLE_ESC[i]) if (b == SIMPLE_ESC[i]) known = 1'b1;
    end while (known);
    return b;
  endfunction

  // Sends a backslash-u escape with the unit's four digits in mixed case.
  // A digit is occasionally replaced by a non-hex byte.
  task automatic send_unit(input logic [15:0] u);
    logic [3:0] nib;
    logic [7:0] ch;
    send_body(CH_BSLASH);
    send_body(CH_U);
    for (int i = 3; i >= 0 && !aborted; i--) begin
      nib = u[4*i +: 4];
      if (nib < 4'd10) ch = 8'h30 + {4'b0000, nib};
      else ch = (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + {4'b0000, nib} - 8'd10;
      if ($urandom_range(0, 49) == 0) begin
        ch = rand_not_hex();
        aborted = 1'b1;
      end
      send_body(ch);
    end
  endtask

  // One piece of string content: a plain byte, a simple escape, a unit escape or
  // surrogate pair, or now and then an unknown escape letter.
  task automatic send_token();
    int          sel;
    logic [15:0] u;
    logic [15:0] lo;
    sel = $urandom_range(0, 9);
    if (sel <= 3) begin
      send_body(rand_plain());
    end else if (sel <= 5) begin
      send_body(CH_BSLASH);
      send_body(SIMPLE_ESC[$urandom_range(0, 7)]);
    end else if (sel == 9 && $urandom_range(0, 2) == 0) begin
      send_body(CH_BSLASH);
      send_body(rand_bad_escape());
      aborted = 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0:       u = 16'($urandom_range(0, 16'h7F));
        1:       u = 16'($urandom_range(16'h80, 16'h7FF));
        2, 3:    u = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                                 : 16'($urandom_range(16'hE000, 16'hFFFF));
        4:       u = BOUNDARY_UNITS[$urandom_range(0, 7)];
        5:       u = 16'($urandom_range(16'hDC00, 16'hDFFF));
        default: u = 16'($urandom_range(16'hD800, 16'hDBFF));
      endcase
      send_unit(u);
      if (!aborted && u >= 16'hD800 && u <= 16'hDBFF) begin
        if ($urandom_range(0, 7) == 0) begin
          // Break the pair: no backslash, or a backslash followed by something else.
          if ($urandom_range(0, 1) == 1) begin
            send_body(rand_plain());
          end else begin
            send_body(CH_BSLASH);
            send_body(rand_bad_escape());
          end
          aborted = 1'b1;
        end else begin
          // The second unit is mostly a proper low surrogate, sometimes any value.
          lo = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                           : 16'($urandom_range(16'hDC00, 16'hDFFF));
          send_unit(lo);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes other than a quote while waiting each give one error; the end of the
  // buffer adds nothing there.
  task automatic test_idle_noise();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  // An opening quote that is the last byte of the buffer is an error.
  task automatic test_open_at_end();
    send_word(CH_QUOTE, 1'b1);
  endtask

  task automatic test_bad_escape();
    send_text("\"\\q", 1'b0);
  endtask

  // The largest pair, lower-case digits on the second unit, and a closing quote
  // that is also the last byte, which gives done only.
  task automatic test_surrogate_pair();
    send_text("\"\\uDBFF\\udfff\"", 1'b1);
  endtask

  task automatic test_bad_hex();
    send_text("\"\\u0G", 1'b0);
  endtask

  // Mostly well-formed strings with random content; some are broken on purpose.
  // Halfway through, the sender holds off until everything has drained.
  task automatic test_random_strings(input int count);
    int stop_at;
    int ntok;
    bit drained;
    stop_at = sent_words + count;
    drained = 1'b0;
    while (sent_words < stop_at) begin
      if (!drained && sent_words >= stop_at - count / 2) begin
        wait_drain();
        drained = 1'b1;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) send_word(rand_plain(), 1'($urandom_range(0, 1)));
      aborted = 1'b0;
      send_body(CH_QUOTE);
      ntok = $urandom_range(0, 6);
      for (int k = 0; k < ntok && !aborted; k++) send_token();
      if (!aborted) send_word(CH_QUOTE, 1'($urandom_range(0, 1)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin : run_tests
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_idle_noise();
    test_open_at_end();
    test_bad_escape();
    test_surrogate_pair();
    test_bad_hex();
    test_random_strings(290);
    wait_drain();
    // Give any stray word time to show up after the last expected one.
    repeat (16) @(posedge clk);
    if (pending_q.size() != 0) begin
      mismatches += pending_q.size();
      $display("%0d expected words never arrived", pending_q.size());
    end
    if (mismatches == 0) begin
      $display("json_string_unescape_utf8_core: match");
    end else begin
      $display("json_string_unescape_utf8_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("json_string_unescape_utf8_core: mismatch");
    $finish;
  end

endmodule
